// ===== hdl/bchc_pkg.sv =====
// ----------------------------------------------------------------------------
// bchc_pkg
// Shared types and constants for the button click and hold classifier.
// ----------------------------------------------------------------------------
package bchc_pkg;

  localparam int unsigned CfgWidth = 16;
  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  localparam logic [CfgWidth-1:0] ClickLimitRst = 16'd400;
  localparam logic [CfgWidth-1:0] SingleWindowRst = 16'd600;
  localparam logic [CfgWidth-1:0] TripleWindowRst = 16'd1000;
  localparam logic [CfgWidth-1:0] HoldLimitRst = 16'd2500;

  localparam logic [1:0] TripleCount = 2'd3;

  typedef enum logic [1:0] {
    REG_CLICK_LIMIT   = 2'd0,
    REG_SINGLE_WINDOW = 2'd1,
    REG_TRIPLE_WINDOW = 2'd2,
    REG_HOLD_LIMIT    = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_TRIPLE = 2'd2,
    EV_HOLD   = 2'd3
  } event_e;

  typedef struct packed {
    logic [CfgWidth-1:0] click_limit;
    logic [CfgWidth-1:0] single_window;
    logic [CfgWidth-1:0] triple_window;
    logic [CfgWidth-1:0] hold_limit;
  } cfg_t;

  typedef struct packed {
    logic       press_active;
    logic [1:0] click_tally;
  } status_t;

endpackage

// ===== hdl/bchc_regs.sv =====
// ----------------------------------------------------------------------------
// bchc_regs
// APB-style register file holding the four timing limits.
// ----------------------------------------------------------------------------
module bchc_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bchc_pkg::AddrWidth-1:0] paddr,
  input  logic [bchc_pkg::DataWidth-1:0] pwdata,
  output logic [bchc_pkg::DataWidth-1:0] prdata,
  output logic                         pready,
  output bchc_pkg::cfg_t               cfg_o
);
  import bchc_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.click_limit   <= ClickLimitRst;
      cfg_q.single_window <= SingleWindowRst;
      cfg_q.triple_window <= TripleWindowRst;
      cfg_q.hold_limit    <= HoldLimitRst;
    end else if (wr_en) begin
      case (idx)
        REG_CLICK_LIMIT:   cfg_q.click_limit   <= pwdata[CfgWidth-1:0];
        REG_SINGLE_WINDOW: cfg_q.single_window <= pwdata[CfgWidth-1:0];
        REG_TRIPLE_WINDOW: cfg_q.triple_window <= pwdata[CfgWidth-1:0];
        REG_HOLD_LIMIT:    cfg_q.hold_limit    <= pwdata[CfgWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_CLICK_LIMIT:   prdata[CfgWidth-1:0] = cfg_q.click_limit;
      REG_SINGLE_WINDOW: prdata[CfgWidth-1:0] = cfg_q.single_window;
      REG_TRIPLE_WINDOW: prdata[CfgWidth-1:0] = cfg_q.triple_window;
      REG_HOLD_LIMIT:    prdata[CfgWidth-1:0] = cfg_q.hold_limit;
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== hdl/bchc_core.sv =====
// ----------------------------------------------------------------------------
// bchc_core
// Press and click tracking state with its single-tick update logic.
// ----------------------------------------------------------------------------
module bchc_core #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 level_low_i,
  input  bchc_pkg::cfg_t       cfg_i,
  output bchc_pkg::event_e     event_o,
  output bchc_pkg::status_t    status_o
);
  import bchc_pkg::*;

  localparam int unsigned CmpWidth = (TIMER_BITS > CfgWidth) ? TIMER_BITS : CfgWidth;

  logic                  press_active_q, press_active_d;
  logic [TIMER_BITS-1:0] press_ticks_q, press_ticks_d;
  logic [1:0]            click_tally_q, click_tally_d;
  logic [TIMER_BITS-1:0] first_click_q, first_click_d;
  event_e                event_d;
  logic                  done;

  always_comb begin
    press_active_d = press_active_q;
    press_ticks_d  = press_ticks_q;
    click_tally_d  = click_tally_q;
    first_click_d  = first_click_q;
    event_d        = EV_NONE;
    done           = 1'b0;

    if (press_active_q && (press_ticks_q != '1)) begin
      press_ticks_d = press_ticks_q + TIMER_BITS'(1);
    end
    if ((click_tally_q != 2'd0) && (first_click_q != '1)) begin
      first_click_d = first_click_q + TIMER_BITS'(1);
    end

    if (level_low_i && !press_active_q) begin
      press_active_d = 1'b1;
      press_ticks_d  = '0;
    end else if (!level_low_i && press_active_q) begin
      press_active_d = 1'b0;
      if (CmpWidth'(press_ticks_d) < CmpWidth'(cfg_i.click_limit)) begin
        if (click_tally_q == 2'd0) begin
          first_click_d = '0;
        end
        click_tally_d = click_tally_q + 2'd1;
        if (click_tally_d == TripleCount) begin
          click_tally_d = 2'd0;
          event_d       = EV_TRIPLE;
          done          = 1'b1;
        end
      end
    end

    if (!done) begin
      if ((click_tally_d == 2'd1) &&
          (CmpWidth'(first_click_d) > CmpWidth'(cfg_i.single_window))) begin
        click_tally_d = 2'd0;
        event_d       = EV_SINGLE;
        done          = 1'b1;
      end else if ((click_tally_d > 2'd1) &&
                   (CmpWidth'(first_click_d) > CmpWidth'(cfg_i.triple_window))) begin
        click_tally_d = 2'd0;
      end
    end

    if (!done && press_active_d &&
        (CmpWidth'(press_ticks_d) >= CmpWidth'(cfg_i.hold_limit))) begin
      press_active_d = 1'b0;
      click_tally_d  = 2'd0;
      event_d        = EV_HOLD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_active_q <= 1'b0;
      press_ticks_q  <= '0;
      click_tally_q  <= 2'd0;
      first_click_q  <= '0;
    end else if (step_i) begin
      press_active_q <= press_active_d;
      press_ticks_q  <= press_ticks_d;
      click_tally_q  <= click_tally_d;
      first_click_q  <= first_click_d;
    end
  end

  assign event_o = event_d;
  assign status_o.press_active = press_active_q;
  assign status_o.click_tally  = click_tally_q;

endmodule

// ===== hdl/button_click_hold_classifier.sv =====
// ----------------------------------------------------------------------------
// button_click_hold_classifier
// Classifies a sampled push button into single clicks, triple clicks and holds.
// ----------------------------------------------------------------------------
// Each input beat on the in channel is one tick carrying the sampled button
// level, with level_low_i high while the button is pressed.
// Every accepted beat produces exactly one output beat whose event_code_o is
// none, single click, triple click or long hold.
// The result of a beat is presented from the output register in the cycle
// after it is accepted, and one beat is taken in every cycle while the output
// side keeps up.
// The tracking state advances only on accepted beats, so idle cycles do not
// count as ticks.
// When the receiver stalls, the pending result is held and in_ready_o stays
// high only in the cycle where that result is being taken.
// Reset clears the press and click state, empties the output register and
// loads the default limits of 400, 600, 1000 and 2500 ticks.
// The limits are written over the APB port at byte addresses 0, 4, 8 and 12;
// the user must do this while no beat is outstanding; the block has no check.
// ----------------------------------------------------------------------------
module button_click_hold_classifier #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bchc_pkg::AddrWidth-1:0] paddr,
  input  logic [bchc_pkg::DataWidth-1:0] pwdata,
  output logic [bchc_pkg::DataWidth-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           level_low_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     event_code_o
);
  import bchc_pkg::*;

  cfg_t    cfg;
  status_t status;
  event_e  event_next;
  event_e  event_q;
  logic    out_valid_q;
  logic    accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  bchc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bchc_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .level_low_i (level_low_i),
    .cfg_i       (cfg),
    .event_o     (event_next),
    .status_o    (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      event_q <= event_next;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_code_o = event_q;

`ifndef SYNTHESIS
  a_accept_gives_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni) accept |=> out_valid_o
  ) else $error("accepted beat produced no result");

  a_tally_below_three : assert property (
    @(posedge clk_i) disable iff (!rst_ni) status.click_tally != TripleCount
  ) else $error("click tally reached three");

  a_hold_ends_press : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (accept && (event_next == EV_HOLD)) |=>
        (!status.press_active && (status.click_tally == 2'd0))
  ) else $error("hold left a press or clicks pending");

  a_triple_clears_tally : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (accept && (event_next == EV_TRIPLE)) |=> (status.click_tally == 2'd0)
  ) else $error("triple click left clicks pending");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the button click and hold classifier.
// ----------------------------------------------------------------------------
// Ticks of the sampled button level go in on the valid/ready input channel and
// every beat's event code is compared with a cycle-free model of the
// classifier kept inside this bench. A directed table covers the default
// limits, a scaled-down limit set, the largest and smallest limits and zero
// windows. Random presses, click bursts and noise then run under several small
// limit settings written over APB while the block is idle. Both channels stall
// at random in shifting proportions, except in the final random phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bchc_pkg::*;

  typedef enum logic {ROW_TICKS, ROW_LIMITS} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        lvl;
    logic [31:0] reps;
    logic        typed;
    event_e      want;
  } dir_row_t;

  localparam int NumRows = 34;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 level_low_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [1:0]           event_code_o;

  // Shadow of the limit registers.
  logic [CfgWidth-1:0] lim_click = ClickLimitRst;
  logic [CfgWidth-1:0] win_single = SingleWindowRst;
  logic [CfgWidth-1:0] win_triple = TripleWindowRst;
  logic [CfgWidth-1:0] lim_hold = HoldLimitRst;

  // Classifier state.
  logic                btn_pressed = 1'b0;
  logic [CfgWidth-1:0] press_len = '0;
  logic [1:0]          clicks_held = '0;
  logic [CfgWidth-1:0] since_first_click = '0;

  event_e      expected_events[$];
  int unsigned err_count = 0;
  int unsigned ticks_sent = 0;
  int unsigned settings_used = 0;
  int unsigned events_seen[4] = '{0, 0, 0, 0};
  int          send_idle_pct = 33;
  int          recv_idle_pct = 61;

  logic [CfgWidth-1:0] limit_sets[5][4] = '{
    '{16'd20, 16'd30, 16'd50, 16'd120},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{16'd1, 16'd1, 16'd1, 16'd1},
    '{16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd2, 16'd0, 16'd0, 16'd3}
  };

  dir_row_t plan[NumRows];

  button_click_hold_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .level_low_i (level_low_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .event_code_o(event_code_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void log_error(string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic event_e classify_tick(logic lvl);
    if (btn_pressed && press_len != '1) begin
      press_len++;
    end
    if (clicks_held != 0 && since_first_click != '1) begin
      since_first_click++;
    end
    if (lvl && !btn_pressed) begin
      btn_pressed = 1'b1;
      press_len = '0;
    end else if (!lvl && btn_pressed) begin
      btn_pressed = 1'b0;
      if (press_len < lim_click) begin
        if (clicks_held == 0) begin
          since_first_click = '0;
        end
        clicks_held++;
        if (clicks_held >= TripleCount) begin
          clicks_held = '0;
          return EV_TRIPLE;
        end
      end
    end
    if (clicks_held == 2'd1 && since_first_click > win_single) begin
      clicks_held = '0;
      return EV_SINGLE;
    end
    if (clicks_held > 2'd1 && since_first_click > win_triple) begin
      clicks_held = '0;
    end
    if (btn_pressed && press_len >= lim_hold) begin
      btn_pressed = 1'b0;
      clicks_held = '0;
      return EV_HOLD;
    end
    return EV_NONE;
  endfunction

  always @(posedge clk_i) begin : result_check
    event_e want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      events_seen[event_code_o]++;
      if (expected_events.size() == 0) begin
        log_error($sformatf("unexpected result beat with event %0d", event_code_o));
      end else begin
        want = expected_events.pop_front();
        if (event_code_o !== want) begin
          log_error($sformatf("event mismatch: expected %s (%0d), got %0d",
                              want.name(), want, event_code_o));
        end
      end
    end
  end

  task automatic send_tick(logic lvl, logic typed, event_e want);
    event_e modeled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    level_low_i <= lvl;
    do @(posedge clk_i); while (!in_ready_o);
    modeled = classify_tick(lvl);
    expected_events.push_back(typed ? want : modeled);
    ticks_sent++;
  endtask

  task automatic hold_level(logic lvl, int unsigned n);
    repeat (n) send_tick(lvl, 1'b0, EV_NONE);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [CfgWidth-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DataWidth'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reg_check(reg_idx_e idx, logic [CfgWidth-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== DataWidth'(want)) begin
      log_error($sformatf("register %s read back %0d, expected %0d",
                          idx.name(), prdata, want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_limits(logic [CfgWidth-1:0] cl, logic [CfgWidth-1:0] sw,
                              logic [CfgWidth-1:0] tw, logic [CfgWidth-1:0] hl);
    logic [CfgWidth-1:0] vals[4];
    vals = '{cl, sw, tw, hl};
    for (int i = 0; i < 4; i++) begin
      reg_write(reg_idx_e'(i), vals[i]);
      reg_check(reg_idx_e'(i), vals[i]);
    end
    lim_click  = cl;
    win_single = sw;
    win_triple = tw;
    lim_hold   = hl;
    settings_used++;
  endtask

  // Mostly click bursts and long presses sized to the current limits.
  task automatic random_phase(int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int unsigned click_top;
    int unsigned long_lo;
    start     = ticks_sent;
    click_top = (lim_click > 1) ? lim_click - 1 : 1;
    long_lo   = (lim_hold > 2) ? lim_hold - 2 : 1;
    while (ticks_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        repeat ($urandom_range(1, 3)) begin
          hold_level(1'b1, $urandom_range(1, click_top + 1));
          hold_level(1'b0, $urandom_range(1, 3));
        end
        hold_level(1'b0, $urandom_range(0, win_triple + 3));
      end else if (pick < 80) begin
        hold_level(1'b1, $urandom_range(long_lo, 2 * lim_hold + 2));
      end else begin
        repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(1)), 1'b0, EV_NONE);
      end
    end
  endtask

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    plan = '{
      '{ROW_TICKS, 1'b0, 32'd3, 1'b1, EV_NONE},
      '{ROW_TICKS, 1'b1, 32'd1, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b0, 32'd1, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b1, 32'd1, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b0, 32'd1, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b1, 32'd1, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b0, 32'd1, 1'b1, EV_TRIPLE},
      '{ROW_LIMITS, 1'b0, 32'd0, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b1, 32'd121, 1'b1, EV_HOLD},
      '{ROW_TICKS, 1'b1, 32'd121, 1'b1, EV_HOLD},
      '{ROW_TICKS, 1'b1, 32'd19, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b0, 32'd32, 1'b1, EV_SINGLE},
      '{ROW_TICKS, 1'b1, 32'd20, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b0, 32'd40, 1'b1, EV_NONE},
      '{ROW_LIMITS, 1'b0, 32'd1, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b1, 32'd1, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b0, 32'd1, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b0, 32'd200, 1'b1, EV_NONE},
      '{ROW_TICKS, 1'b1, 32'd1, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b0, 32'd1, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b1, 32'd1, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b0, 32'd1, 1'b1, EV_TRIPLE},
      '{ROW_LIMITS, 1'b0, 32'd2, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b1, 32'd2, 1'b1, EV_HOLD},
      '{ROW_TICKS, 1'b1, 32'd1, 1'b1, EV_NONE},
      '{ROW_TICKS, 1'b0, 32'd1, 1'b1, EV_NONE},
      '{ROW_LIMITS, 1'b0, 32'd3, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b1, 32'd1, 1'b1, EV_HOLD},
      '{ROW_TICKS, 1'b1, 32'd1, 1'b1, EV_HOLD},
      '{ROW_TICKS, 1'b0, 32'd1, 1'b1, EV_NONE},
      '{ROW_LIMITS, 1'b0, 32'd4, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b1, 32'd1, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b0, 32'd1, 1'b0, EV_NONE},
      '{ROW_TICKS, 1'b0, 32'd1, 1'b1, EV_SINGLE}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    reg_check(REG_CLICK_LIMIT, ClickLimitRst);
    reg_check(REG_SINGLE_WINDOW, SingleWindowRst);
    reg_check(REG_TRIPLE_WINDOW, TripleWindowRst);
    reg_check(REG_HOLD_LIMIT, HoldLimitRst);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_LIMITS) begin
        drain();
        apply_limits(limit_sets[plan[r].reps][0], limit_sets[plan[r].reps][1],
                     limit_sets[plan[r].reps][2], limit_sets[plan[r].reps][3]);
      end else begin
        for (int unsigned k = 0; k < plan[r].reps; k++) begin
          send_tick(plan[r].lvl, plan[r].typed && (k == plan[r].reps - 1), plan[r].want);
        end
      end
    end

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 61;
        recv_idle_pct = 33;
      end
      if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      apply_limits(CfgWidth'($urandom_range(1, 6)), CfgWidth'($urandom_range(0, 12)),
                   CfgWidth'($urandom_range(0, 20)), CfgWidth'($urandom_range(1, 16)));
      random_phase(180);
    end
    drain();

    if (expected_events.size() != 0) begin
      log_error($sformatf("%0d results never arrived", expected_events.size()));
    end
    $display("Sent %0d button ticks under %0d limit settings, with stalls on both sides.",
             ticks_sent, settings_used);
    $display("Results seen: %0d none, %0d single, %0d triple, %0d hold; %0d errors.",
             events_seen[EV_NONE], events_seen[EV_SINGLE], events_seen[EV_TRIPLE],
             events_seen[EV_HOLD], err_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bchc_pkg.sv
hdl/bchc_regs.sv
hdl/bchc_core.sv
hdl/button_click_hold_classifier.sv
tb/testbench.sv
